@@ src/kfh_pkg.sv @@
package kfh_pkg;

   localparam logic [31:0] HASH_SEED = 32'h811C9DC5;
   localparam logic [31:0] KEY_SEED  = 32'hA3B376C9;
   localparam logic [7:0]  CASE_FOLD = 8'h20;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;
   localparam logic [31:0] FIN_MULT  = 32'h5BD1E995;

   // command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic {
      CMD_BYTE,
      CMD_END
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] mixed;
   } cmd_type;

   function automatic logic [31:0] sext8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

@@ src/keyed_fnv_string_hash.sv @@
// keyed name hash: one name byte per beat in, one 32-bit hash per name out
// input side behaves as a queue: a beat is taken when push is high and full low;
//   req_kind 0 carries a name byte, req_kind 1 (or a zero byte) ends the name
// result side behaves as a queue: rsp_hash_value is valid while empty is low and
//   is taken when pop is high
// the front keeps the rolling key and mixes each byte, then hands a command to
//   a four-entry queue; the back folds bytes into the hash and runs the finaliser
// throughput: one name byte per cycle while full is low; an end beat holds the back
//   for the finaliser (xor-shift, multiply, xor-shift), so full rises when ends come close
// result path: the end beat passes through its queue entry, the finaliser register
//   (xor-shift, then multiply) and the result register (final xor-shift)
// one result register sits at the output; if it is not popped, the back stalls at
//   the next end while bytes keep flowing until the queue fills and full rises
// reset (synchronous) empties both queues and restores hash and key seeds
module keyed_fnv_string_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [7:0]  req_name_byte,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_hash_value
);
   import kfh_pkg::*;

   logic    wr_en;
   cmd_type wr_cmd;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   kfh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_name_byte (req_name_byte),
      .wr_en         (wr_en),
      .wr_cmd        (wr_cmd)
   );

   kfh_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_cmd   (wr_cmd),
      .rd_en    (cmd_pop),
      .full     (full),
      .rd_valid (cmd_valid),
      .rd_cmd   (cmd)
   );

   kfh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ src/kfh_front.sv @@
module kfh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  logic             req_kind,
   input  logic [7:0]       req_name_byte,
   output logic             wr_en,
   output kfh_pkg::cmd_type wr_cmd
);
   import kfh_pkg::*;

   logic [31:0] key_ff;
   logic [31:0] key_in;
   logic [31:0] ext;
   logic [31:0] rot;
   logic        is_end;

   always_comb begin
      // a zero byte closes the name just like an end beat
      is_end       = req_kind | (req_name_byte == 8'd0);
      wr_en        = push & ~full;
      wr_cmd.op    = is_end ? CMD_END : CMD_BYTE;
      wr_cmd.mixed = (req_name_byte | CASE_FOLD) ^ key_ff[7:0];
      ext          = sext8(wr_cmd.mixed);
      rot          = key_ff ^ ext;
      key_in       = key_ff;
      if (wr_en) begin
         if (is_end) begin
            key_in = KEY_SEED;
         end else begin
            key_in = {rot[26:0], rot[31:27]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_SEED;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

@@ src/kfh_cmd_fifo.sv @@
module kfh_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  kfh_pkg::cmd_type wr_cmd,
   input  logic             rd_en,
   output logic             full,
   output logic             rd_valid,
   output kfh_pkg::cmd_type rd_cmd
);
   import kfh_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff;
   logic [CMD_CNT_W-1:0] count_in;

   always_comb begin
      full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
      rd_valid = (count_ff != '0);
      rd_cmd   = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ src/kfh_back.sv @@
module kfh_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  kfh_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             pop,
   output logic             empty,
   output logic [31:0]      rsp_hash_value
);
   import kfh_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_MUL,
      ST_SHIFT
   } state_type;

   state_type   state_ff;
   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] fin_ff;
   logic [31:0] fin_in;
   logic [31:0] res_ff;
   logic        res_valid_ff;
   logic        res_valid_in;
   logic        out_free;

   always_comb begin
      cmd_pop        = (state_ff == ST_RUN) && cmd_valid;
      out_free       = ~res_valid_ff | pop;
      hash_in        = (hash_ff ^ sext8(cmd.mixed)) * FNV_PRIME;
      fin_in         = fin_ff * FIN_MULT;
      empty          = ~res_valid_ff;
      rsp_hash_value = res_ff;
      res_valid_in   = res_valid_ff & ~pop;
      if ((state_ff == ST_SHIFT) && out_free) begin
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         hash_ff      <= HASH_SEED;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         unique case (state_ff)
            ST_RUN: begin
               if (cmd_pop) begin
                  if (cmd.op == CMD_END) begin
                     fin_ff   <= hash_ff ^ (hash_ff >> 13);
                     hash_ff  <= HASH_SEED;
                     state_ff <= ST_MUL;
                  end else begin
                     hash_ff <= hash_in;
                  end
               end
            end
            ST_MUL: begin
               fin_ff   <= fin_in;
               state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               // waits here while the result beat is still unread
               if (out_free) begin
                  res_ff   <= fin_ff ^ (fin_ff >> 15);
                  state_ff <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_mul_to_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_SHIFT)
      else $error("finaliser multiply not followed by shift step");

   a_pop_only_running: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_RUN) && cmd_valid)
      else $error("command taken outside run state");

   a_end_reseeds: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && (cmd.op == CMD_END) |=> hash_ff == HASH_SEED)
      else $error("hash not reseeded after end");

   a_shift_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && !res_valid_ff |=> res_valid_ff && (state_ff == ST_RUN))
      else $error("free result slot not filled");
`endif

endmodule

@@ sim/keyed_fnv_string_hash_tb.sv @@
`timescale 1ns / 1ps

module keyed_fnv_string_hash_tb;
   import kfh_pkg::*;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int IDLE_PCT      = 35;
   localparam int RSP_HOLD      = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_BEATS  = 1550;
   localparam int TAIL_CYCLES   = 20;

   class name_hash_scoreboard;
      logic [31:0] run_hash;
      logic [31:0] roll_key;
      logic [31:0] expected_hashes[$];
      int          errors;

      function new();
         run_hash = HASH_SEED;
         roll_key = KEY_SEED;
         errors   = 0;
      endfunction

      // advance the predicted hash and key by one accepted beat
      function void note_beat(input logic kind, input logic [7:0] name_byte);
         logic [7:0]  mixed;
         logic [31:0] ext;
         logic [31:0] h;
         logic [31:0] k;
         if (kind == KIND_END || name_byte == 8'h00) begin
            h = run_hash;
            h = h ^ (h >> 13);
            h = h * FIN_MULT;
            h = h ^ (h >> 15);
            expected_hashes.push_back(h);
            run_hash = HASH_SEED;
            roll_key = KEY_SEED;
         end else begin
            mixed    = (name_byte | CASE_FOLD) ^ roll_key[7:0];
            ext      = {{24{mixed[7]}}, mixed};
            run_hash = (run_hash ^ ext) * FNV_PRIME;
            k        = roll_key ^ ext;
            roll_key = {k[26:0], k[31:27]};
         end
      endfunction

      function int pending();
         return expected_hashes.size();
      endfunction

      function void check_hash(input logic [31:0] actual);
         logic [31:0] want;
         if (expected_hashes.size() == 0) begin
            $display("%0t: unexpected hash, expected none, actual %08h", $time, actual);
            errors++;
         end else begin
            want = expected_hashes.pop_front();
            if (want !== actual) begin
               $display("%0t: hash mismatch, expected %08h, actual %08h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_kind;
   logic [7:0]  req_name_byte;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_hash_value;

   name_hash_scoreboard sb = new();

   bit quiet;
   bit rsp_hold_req;
   int random_beats;
   int stall_cycles;

   keyed_fnv_string_hash DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_name_byte  (req_name_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_hash_value (rsp_hash_value)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one beat on the request side, with random idle cycles ahead of it unless quiet is set
   task automatic send_beat(input logic kind, input logic [7:0] name_byte);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_kind      <= kind;
      req_name_byte <= name_byte;
      do @(posedge clock); while (full);
      sb.note_beat(kind, name_byte);
      random_beats++;
   endtask

   task automatic send_random_name(input int max_len);
      int         len;
      logic [7:0] b;
      len = $urandom_range(max_len, 0);
      repeat (len) begin
         if ($urandom_range(3) == 0)
            b = 8'($urandom_range(255, 1));
         else
            b = 8'($urandom_range(8'h7E, 8'h20));
         send_beat(KIND_BYTE, b);
      end
      if ($urandom_range(3) == 0)
         send_beat(KIND_BYTE, 8'h00);
      else
         send_beat(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // result side
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            pop <= 1'b0;
            repeat (RSP_HOLD) begin
               @(negedge clock);
               pop <= 1'b0;
            end
         end else begin
            pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_hash(rsp_hash_value);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, stall_cycles);
         $display("keyed_fnv_string_hash_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      push          = 1'b0;
      req_kind      = KIND_BYTE;
      req_name_byte = 8'h00;
      quiet         = 1'b0;
      rsp_hold_req  = 1'b0;
      stall_cycles  = 0;
      random_beats  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty names, by end beat and by zero byte
      send_beat(KIND_END, 8'h00);
      send_beat(KIND_BYTE, 8'h00);
      // the end beat ignores its byte
      send_beat(KIND_BYTE, 8'h41);
      send_beat(KIND_BYTE, 8'h62);
      send_beat(KIND_BYTE, 8'h5A);
      send_beat(KIND_END, 8'hFF);
      // field extremes and sign-extension both ways
      send_beat(KIND_BYTE, 8'hFF);
      send_beat(KIND_BYTE, 8'h80);
      send_beat(KIND_BYTE, 8'h7F);
      send_beat(KIND_BYTE, 8'h01);
      send_beat(KIND_BYTE, 8'h20);
      send_beat(KIND_BYTE, 8'hDF);
      send_beat(KIND_BYTE, 8'h00);
      // case fold: upper and lower case of one name
      send_beat(KIND_BYTE, 8'h4B);
      send_beat(KIND_BYTE, 8'h45);
      send_beat(KIND_END, 8'h00);
      send_beat(KIND_BYTE, 8'h6B);
      send_beat(KIND_BYTE, 8'h65);
      send_beat(KIND_END, 8'hAA);
      // back-to-back ends
      send_beat(KIND_END, 8'h55);
      send_beat(KIND_END, 8'h00);
      wait_drained();

      // hold results back while short names keep coming, so the block fills
      quiet        = 1'b1;
      rsp_hold_req = 1'b1;
      repeat (40) send_random_name(2);
      quiet = 1'b0;
      wait_drained();

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         quiet = (random_beats >= 800 && random_beats < 1000);
         if ($urandom_range(9) == 0)
            send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
         else if ($urandom_range(19) == 0)
            send_random_name(40);
         else
            send_random_name(12);
         if ($urandom_range(99) == 0)
            wait_drained();
      end
      quiet = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("keyed_fnv_string_hash_tb OK");
      end else begin
         $display("keyed_fnv_string_hash_tb NOT OK");
      end
      $finish;
   end

endmodule
